@@ src/tlbtm_pkg.sv @@
// Shared types, constants and helpers for the TLB tag match array.
`timescale 1ns / 1ps
`default_nettype none
package tlbtm_pkg;

    // Number of entries in the array
    localparam int ENTRIES = 32;
    // Bits needed to address one entry
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // Width of the entry index field on the ports
    localparam int PORT_IDX_W = 5;
    // Width that holds both a port index and an internal index
    localparam int EXT_W = (IDX_W > PORT_IDX_W) ? IDX_W : PORT_IDX_W;

    localparam int VPN2_W = 29;
    localparam int MASK_W = 19;
    localparam int ASID_W = 8;

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_PROBE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
    } ctrl_cmd_t;

    // Form VPN2 from an EntryHi-style word: bits 63..62 and 39..13
    function automatic logic [VPN2_W-1:0] make_vpn2(input logic [63:0] word);
        make_vpn2 = {word[63:62], word[39:13]};
    endfunction

    // Pack an entry back into EntryHi form
    function automatic logic [63:0] pack_entry_hi(
        input logic [VPN2_W-1:0] tag,
        input logic              glob,
        input logic [ASID_W-1:0] asid
    );
        pack_entry_hi = {tag[28:27], 22'd0, tag[26:0], glob, 4'd0, asid};
    endfunction

endpackage
`default_nettype wire

@@ src/tlbtm_ctrl.sv @@
// Sequencer for the TLB tag match array: capture, execute, deliver.
`timescale 1ns / 1ps
`default_nettype none
module tlbtm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output tlbtm_pkg::ctrl_cmd_t       cmd
);

    tlbtm_pkg::state_t state_reg;
    tlbtm_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // Hold state and result-valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlbtm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance the sequence and issue commands
    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            tlbtm_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = tlbtm_pkg::ST_EXEC;
                end
            end
            tlbtm_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = tlbtm_pkg::ST_FINISH;
            end
            tlbtm_pkg::ST_FINISH:
            begin
                // Load the result only once the output slot is free
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = tlbtm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlbtm_pkg::ST_IDLE;
            end
        endcase
    end

    // Set on a new result, drop when the beat is taken
    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign rsp_valid = out_valid_reg;

endmodule
`default_nettype wire

@@ src/tlbtm_dp.sv @@
// Datapath: entry storage, parallel tag compare, priority encode, result registers.
`timescale 1ns / 1ps
`default_nettype none
module tlbtm_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tlbtm_pkg::ctrl_cmd_t  cmd,
    input  wire logic [1:0]            operation,
    input  wire logic [4:0]            entry_index,
    input  wire logic [63:0]           entry_high_word,
    input  wire logic                  low0_global_bit,
    input  wire logic                  low1_global_bit,
    input  wire logic [31:0]           page_mask_word,
    input  wire logic [63:0]           virtual_address,
    input  wire logic [7:0]            probe_asid,
    output logic                       miss,
    output logic [4:0]                 hit_index,
    output logic [63:0]                read_entry_high
);

    localparam int N = tlbtm_pkg::ENTRIES;
    localparam int IW = tlbtm_pkg::IDX_W;
    localparam int XW = tlbtm_pkg::EXT_W;
    localparam int VW = tlbtm_pkg::VPN2_W;
    localparam int MW = tlbtm_pkg::MASK_W;
    localparam int AW = tlbtm_pkg::ASID_W;

    // Captured request
    logic [1:0]    op_reg;
    logic [4:0]    idx_reg;
    logic [VW-1:0] wr_vpn_reg;
    logic [AW-1:0] wr_asid_reg;
    logic          wr_glob_reg;
    logic [MW-1:0] wr_mask_reg;
    logic [VW-1:0] pr_vpn_reg;
    logic [AW-1:0] pr_asid_reg;

    // Entry storage
    logic [VW-1:0] tag_reg   [N];
    logic [MW-1:0] mask_reg  [N];
    logic [AW-1:0] asid_reg  [N];
    logic          glob_reg  [N];
    logic [N-1:0]  valid_reg;

    // Execute-stage results
    logic [N-1:0]  match_reg;
    logic [63:0]   rd_word_reg;

    // Output registers
    logic          miss_reg;
    logic [4:0]    hit_reg;
    logic [63:0]   rd_out_reg;

    logic [XW-1:0] idx_ext;
    logic [IW-1:0] idx_sel;
    logic          idx_in_range;
    logic          do_write;
    logic [N-1:0]  match_vec;
    logic [IW-1:0] enc_idx;
    logic [XW-1:0] enc_ext;
    logic [VW-1:0] rd_tag;

    assign idx_ext      = XW'(idx_reg);
    assign idx_sel      = idx_ext[IW-1:0];
    assign idx_in_range = (32'(idx_reg) < 32'(N));
    assign do_write     = cmd.exec && (op_reg == tlbtm_pkg::OP_WRITE) && idx_in_range;

    // Capture the request beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            idx_reg     <= entry_index;
            wr_vpn_reg  <= tlbtm_pkg::make_vpn2(entry_high_word);
            wr_asid_reg <= entry_high_word[7:0];
            wr_glob_reg <= low0_global_bit & low1_global_bit;
            wr_mask_reg <= ~page_mask_word[31:13];
            pr_vpn_reg  <= tlbtm_pkg::make_vpn2(virtual_address);
            pr_asid_reg <= probe_asid;
        end
    end

    // Write entry fields that have a reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < N; i++)
            begin
                mask_reg[i] <= '0;
                asid_reg[i] <= '0;
                glob_reg[i] <= 1'b0;
            end
        end
        else if (do_write)
        begin
            valid_reg[idx_sel] <= 1'b1;
            mask_reg[idx_sel]  <= wr_mask_reg;
            asid_reg[idx_sel]  <= wr_asid_reg;
            glob_reg[idx_sel]  <= wr_glob_reg;
        end
    end

    // Write tag; an entry that is not valid never matches and reads with an all-ones tag
    always_ff @(posedge clk)
    begin
        if (do_write)
            tag_reg[idx_sel] <= wr_vpn_reg;
    end

    // Compare every entry against the probe in parallel
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            match_vec[i] = valid_reg[i]
                && ((pr_vpn_reg & {{(VW-MW){1'b1}}, mask_reg[i]}) == tag_reg[i])
                && ((asid_reg[i] == pr_asid_reg) || glob_reg[i]);
        end
    end

    assign rd_tag = valid_reg[idx_sel] ? tag_reg[idx_sel] : {VW{1'b1}};

    // Register the match vector and the read word
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            match_reg <= match_vec;
            if ((op_reg == tlbtm_pkg::OP_READ) && idx_in_range)
                rd_word_reg <= tlbtm_pkg::pack_entry_hi(rd_tag, glob_reg[idx_sel],
                                                        asid_reg[idx_sel]);
            else
                rd_word_reg <= '0;
        end
    end

    // Pick the lowest matching entry
    always_comb
    begin
        enc_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (match_reg[i])
                enc_idx = IW'(i);
        end
    end

    assign enc_ext = XW'(enc_idx);

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (op_reg == tlbtm_pkg::OP_PROBE)
            begin
                miss_reg <= (match_reg == '0);
                hit_reg  <= enc_ext[4:0];
            end
            else
            begin
                miss_reg <= 1'b0;
                hit_reg  <= '0;
            end
            rd_out_reg <= rd_word_reg;
        end
    end

    assign miss            = miss_reg;
    assign hit_index       = hit_reg;
    assign read_entry_high = rd_out_reg;

endmodule
`default_nettype wire

@@ src/tlb_tag_match_array.sv @@
// Top level of the TLB tag match array: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Tag side of a fully associative MIPS-style TLB. Each request beat writes an
// entry, reads an entry back in EntryHi form, or probes an address against all
// entries and returns the lowest matching index (or a miss); the unused code
// does nothing. Every request gives exactly one response beat. The accepting
// edge captures the beat; the execute state then does the entry write, entry
// read or the parallel compare of all entries, and the finish state loads the
// priority encode into the output register. The sequencer takes one request
// at a time and returns to idle as the response loads, so it accepts no new
// request before the last one has loaded its response. A new request may be
// accepted while the previous response still waits in the output register; that
// request then holds in its finish state until the waiting beat is taken. Entries
// are empty after reset; an empty entry never matches and reads back with an
// all-ones VPN2, global 0 and ASID 0.
module tlb_tag_match_array (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [4:0]  entry_index,
    input  wire logic [63:0] entry_high_word,
    input  wire logic        low0_global_bit,
    input  wire logic        low1_global_bit,
    input  wire logic [31:0] page_mask_word,
    input  wire logic [63:0] virtual_address,
    input  wire logic [7:0]  probe_asid,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic             miss,
    output logic [4:0]       hit_index,
    output logic [63:0]      read_entry_high
);

    tlbtm_pkg::ctrl_cmd_t cmd;

    tlbtm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    tlbtm_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .operation       (operation),
        .entry_index     (entry_index),
        .entry_high_word (entry_high_word),
        .low0_global_bit (low0_global_bit),
        .low1_global_bit (low1_global_bit),
        .page_mask_word  (page_mask_word),
        .virtual_address (virtual_address),
        .probe_asid      (probe_asid),
        .miss            (miss),
        .hit_index       (hit_index),
        .read_entry_high (read_entry_high)
    );

endmodule
`default_nettype wire

@@ tb/tb_tlb_tag_match_array.sv @@
// Self-checking testbench for the TLB tag match array: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_tlb_tag_match_array;
    import tlbtm_pkg::*;

    // Operation code that the block must treat as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_PER_PHASE = 528;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;
    // Read-back of an entry that was never written: all-ones VPN2, global 0, ASID 0
    localparam logic [63:0] RD_EMPTY = 64'hC000_00FF_FFFF_E000;
    // Read-back of an entry written with all-ones EntryHi and both global bits set
    localparam logic [63:0] RD_ALL_ONES = 64'hC000_00FF_FFFF_F0FF;

    typedef struct {
        logic [1:0]  op;
        logic [4:0]  idx;
        logic [63:0] hi_word;
        logic        g0;
        logic        g1;
        logic [31:0] pmask;
        logic [63:0] vaddr;
        logic [7:0]  asid;
    } tlb_req_t;

    typedef struct {
        logic        miss;
        logic [4:0]  hit;
        logic [63:0] rd;
    } tlb_rsp_t;

    typedef struct {
        tlb_req_t req;
        bit       typed;
        tlb_rsp_t rsp;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [1:0]  operation;
    logic [4:0]  entry_index;
    logic [63:0] entry_high_word;
    logic        low0_global_bit;
    logic        low1_global_bit;
    logic [31:0] page_mask_word;
    logic [63:0] virtual_address;
    logic [7:0]  probe_asid;
    logic        rsp_valid;
    logic        rsp_ready;
    logic        miss;
    logic [4:0]  hit_index;
    logic [63:0] read_entry_high;

    // Shadow copy of the tag array
    logic [31:0] shadow_tag [ENTRIES];
    logic [31:0] shadow_inv_mask [ENTRIES];
    logic        shadow_glob [ENTRIES];
    logic [7:0]  shadow_asid [ENTRIES];

    tlb_rsp_t responses_due[$];
    dir_row_t directed_rows[$];
    logic [28:0] vpn_pool [8];
    logic [7:0]  asid_pool [4];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int cycle_count;
    int n_writes;
    int n_reads;
    int n_probes;
    int n_hits;
    int n_unused;

    tlb_tag_match_array i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .operation       (operation),
        .entry_index     (entry_index),
        .entry_high_word (entry_high_word),
        .low0_global_bit (low0_global_bit),
        .low1_global_bit (low1_global_bit),
        .page_mask_word  (page_mask_word),
        .virtual_address (virtual_address),
        .probe_asid      (probe_asid),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .miss            (miss),
        .hit_index       (hit_index),
        .read_entry_high (read_entry_high)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // VPN2 of an EntryHi-style word: bits 63..62 on top of bits 39..13
    function automatic logic [31:0] vpn2_of(input logic [63:0] w);
        return {3'b000, w[63:62], w[39:13]};
    endfunction

    // Apply one beat to the shadow array and return the response it should produce
    function automatic tlb_rsp_t apply_to_shadow(input tlb_req_t r);
        tlb_rsp_t    res;
        logic [63:0] t64;
        logic [31:0] v;
        logic        found;
        res.miss = 1'b0;
        res.hit = '0;
        res.rd = '0;
        found = 1'b0;
        case (r.op)
            OP_WRITE:
            begin
                n_writes++;
                if (r.idx < ENTRIES)
                begin
                    shadow_inv_mask[r.idx] = ~(r.pmask >> 13);
                    shadow_tag[r.idx] = vpn2_of(r.hi_word);
                    shadow_glob[r.idx] = r.g0 & r.g1;
                    shadow_asid[r.idx] = r.hi_word[7:0];
                end
            end
            OP_READ:
            begin
                n_reads++;
                if (r.idx < ENTRIES)
                begin
                    t64 = {32'd0, shadow_tag[r.idx]};
                    res.rd = ((t64 & 64'h1800_0000) << 35) | ((t64 & 64'h07FF_FFFF) << 13) |
                             ({63'd0, shadow_glob[r.idx]} << 12) | {56'd0, shadow_asid[r.idx]};
                end
            end
            OP_PROBE:
            begin
                n_probes++;
                v = vpn2_of(r.vaddr);
                // lowest matching entry wins
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!found && (v & shadow_inv_mask[i]) == shadow_tag[i] &&
                        (shadow_asid[i] == r.asid || shadow_glob[i]))
                    begin
                        found = 1'b1;
                        res.hit = i[4:0];
                    end
                end
                res.miss = !found;
                if (found)
                    n_hits++;
            end
            default:
                n_unused++;
        endcase
        return res;
    endfunction

    function automatic tlb_req_t mk(input logic [1:0] op, input logic [4:0] idx,
                                    input logic [63:0] hi, input logic g0, input logic g1,
                                    input logic [31:0] pm, input logic [63:0] va,
                                    input logic [7:0] asid);
        tlb_req_t r;
        r.op = op;
        r.idx = idx;
        r.hi_word = hi;
        r.g0 = g0;
        r.g1 = g1;
        r.pmask = pm;
        r.vaddr = va;
        r.asid = asid;
        return r;
    endfunction

    function automatic tlb_rsp_t rsp_of(input logic m, input logic [4:0] h,
                                        input logic [63:0] rd);
        tlb_rsp_t e;
        e.miss = m;
        e.hit = h;
        e.rd = rd;
        return e;
    endfunction

    function automatic void add_row(input tlb_req_t r, input bit typed, input tlb_rsp_t e);
        dir_row_t row;
        row.req = r;
        row.typed = typed;
        row.rsp = e;
        directed_rows.push_back(row);
    endfunction

    // Common page sizes, with noise in the ignored low bits and now and then a random mask
    function automatic logic [31:0] page_mask_pick();
        logic [31:0] pm;
        case ($urandom_range(0, 7))
            0: pm = 32'h0000_0000;
            1: pm = 32'h0000_6000;
            2: pm = 32'h0001_E000;
            3: pm = 32'h0007_E000;
            4: pm = 32'h001F_E000;
            5: pm = 32'h007F_E000;
            6: pm = 32'h01FF_E000;
            default: pm = $urandom;
        endcase
        return pm | ($urandom & 32'h0000_1FFF);
    endfunction

    // Random beat: mostly writes of pooled tags and probes near them, some pure noise
    function automatic tlb_req_t random_request();
        tlb_req_t    r;
        logic [31:0] pm;
        logic [31:0] rnd;
        logic [28:0] tag;
        int          pick;
        r = mk(OP_WRITE, 5'($urandom_range(0, 31)), {$urandom, $urandom},
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
               {$urandom, $urandom}, 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            r.op = OP_WRITE;
            if ($urandom_range(0, 9) != 0)
            begin
                pm = page_mask_pick();
                tag = vpn_pool[$urandom_range(0, 7)];
                // keep the tag clear under its mask most of the time
                if ($urandom_range(0, 7) != 0)
                    tag = tag & ~{10'd0, pm[31:13]};
                r.hi_word[63:62] = tag[28:27];
                r.hi_word[39:13] = tag[26:0];
                if ($urandom_range(0, 3) != 0)
                    r.hi_word[7:0] = asid_pool[$urandom_range(0, 3)];
                r.pmask = pm;
            end
        end
        else if (pick < 45)
            r.op = OP_READ;
        else if (pick < 95)
        begin
            r.op = OP_PROBE;
            if ($urandom_range(0, 5) != 0)
            begin
                pm = page_mask_pick();
                rnd = $urandom;
                tag = vpn_pool[$urandom_range(0, 7)] ^ (rnd[28:0] & {10'd0, pm[31:13]});
                r.vaddr[63:62] = tag[28:27];
                r.vaddr[39:13] = tag[26:0];
                if ($urandom_range(0, 3) != 0)
                    r.asid = asid_pool[$urandom_range(0, 3)];
            end
        end
        else
            r.op = OP_UNUSED;
        return r;
    endfunction

    // Drive one request beat at the falling edge, hold it until accepted
    task automatic send_request(input tlb_req_t r, input bit typed, input tlb_rsp_t typed_rsp);
        tlb_rsp_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        operation <= r.op;
        entry_index <= r.idx;
        entry_high_word <= r.hi_word;
        low0_global_bit <= r.g0;
        low1_global_bit <= r.g1;
        page_mask_word <= r.pmask;
        virtual_address <= r.vaddr;
        probe_asid <= r.asid;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = apply_to_shadow(r);
        responses_due.push_back(typed ? typed_rsp : predicted);
    endtask

    // Response side back-pressure
    always @(negedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Check each response beat against the oldest expectation; watch for a hang
    always @(posedge clk)
    begin : rsp_monitor
        tlb_rsp_t e;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_tlb_tag_match_array: FAIL");
            $finish;
        end
        else if (rst_n && rsp_valid && rsp_ready)
        begin
            if (responses_due.size() == 0)
            begin
                $error("response beat with nothing expected");
                error_count++;
            end
            else
            begin
                e = responses_due.pop_front();
                if (miss !== e.miss)
                begin
                    $error("miss: expected %0b, got %0b", e.miss, miss);
                    error_count++;
                end
                if (hit_index !== e.hit)
                begin
                    $error("hit_index: expected %0d, got %0d", e.hit, hit_index);
                    error_count++;
                end
                if (read_entry_high !== e.rd)
                begin
                    $error("read_entry_high: expected %h, got %h", e.rd, read_entry_high);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        tlb_rsp_t none;
        logic [63:0] ehw5;
        logic [63:0] ehw6;
        none = rsp_of(1'b0, 5'd0, 64'd0);
        ehw5 = 64'h8000_0012_3400_005A;
        ehw6 = ehw5 | 64'h2000;

        rst_n = 1'b0;
        req_valid = 1'b0;
        operation = OP_WRITE;
        entry_index = '0;
        entry_high_word = '0;
        low0_global_bit = 1'b0;
        low1_global_bit = 1'b0;
        page_mask_word = '0;
        virtual_address = '0;
        probe_asid = '0;
        rsp_ready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        n_writes = 0;
        n_reads = 0;
        n_probes = 0;
        n_hits = 0;
        n_unused = 0;
        send_idle_pct = 6;
        recv_idle_pct = 64;

        // shadow array after reset
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_tag[i] = 32'hFFFF_FFFF;
            shadow_inv_mask[i] = '0;
            shadow_glob[i] = 1'b0;
            shadow_asid[i] = '0;
        end
        for (int i = 0; i < 8; i++)
            vpn_pool[i] = 29'($urandom);
        for (int i = 0; i < 4; i++)
            asid_pool[i] = 8'($urandom);

        // Directed table: empty entries, extremes, unused op, masking and priority
        add_row(mk(OP_READ, 5'd0, '0, 0, 0, '0, '0, '0), 1, rsp_of(0, 0, RD_EMPTY));
        add_row(mk(OP_READ, 5'd31, '0, 0, 0, '0, '0, '0), 1, rsp_of(0, 0, RD_EMPTY));
        add_row(mk(OP_PROBE, 5'd0, '0, 0, 0, '0, '0, 8'h00), 1, rsp_of(1, 0, 0));
        add_row(mk(OP_PROBE, 5'd31, '1, 1, 1, '1, '1, 8'hFF), 1, rsp_of(1, 0, 0));
        add_row(mk(OP_UNUSED, 5'd31, '1, 1, 1, '1, '1, 8'hFF), 1, none);
        add_row(mk(OP_WRITE, 5'd0, '1, 1, 1, 32'd0, '0, '0), 1, none);
        add_row(mk(OP_READ, 5'd0, '0, 0, 0, '0, '0, '0), 1, rsp_of(0, 0, RD_ALL_ONES));
        add_row(mk(OP_PROBE, 5'd0, '0, 0, 0, '0, '1, 8'h00), 1, rsp_of(0, 0, 0));
        add_row(mk(OP_WRITE, 5'd31, '0, 1, 0, 32'd0, '1, '1), 1, none);
        add_row(mk(OP_READ, 5'd31, '1, 1, 1, '1, '1, '1), 1, rsp_of(0, 0, 0));
        add_row(mk(OP_PROBE, 5'd0, '0, 0, 0, '0, '0, 8'h00), 1, rsp_of(0, 31, 0));
        add_row(mk(OP_PROBE, 5'd0, '0, 0, 0, '0, '0, 8'h01), 1, rsp_of(1, 0, 0));
        // 16 MB page, private ASID
        add_row(mk(OP_WRITE, 5'd5, ehw5, 0, 1, 32'h01FF_E000, '0, '0), 0, none);
        add_row(mk(OP_PROBE, 5'd0, '0, 0, 0, '0, ehw5 | 64'h01FF_E000, 8'h5A), 0, none);
        add_row(mk(OP_PROBE, 5'd0, '0, 0, 0, '0, ehw5, 8'h5B), 0, none);
        // tag with a bit set under its own mask never matches
        add_row(mk(OP_WRITE, 5'd6, ehw6, 1, 1, 32'h01FF_E000, '0, '0), 0, none);
        add_row(mk(OP_PROBE, 5'd0, '0, 0, 0, '0, ehw6, 8'h00), 0, none);
        // lower global entry wins over a matching private one
        add_row(mk(OP_WRITE, 5'd3, ehw5 & ~64'hFF, 1, 1, 32'h01FF_E000, '0, '0), 0, none);
        add_row(mk(OP_PROBE, 5'd0, '0, 0, 0, '0, ehw5 | 64'h0000_A000, 8'h5A), 0, none);
        // largest mask compares only the top VPN2 bits
        add_row(mk(OP_WRITE, 5'd7, 64'h4000_0000_0000_0011, 1, 0, '1, '0, '0), 0, none);
        add_row(mk(OP_PROBE, 5'd0, '0, 0, 0, '0, 64'h4000_0000_FFFF_FFFF, 8'h11), 0, none);
        add_row(mk(OP_READ, 5'd5, '0, 0, 0, '0, '0, '0), 0, none);
        add_row(mk(OP_READ, 5'd7, '0, 0, 0, '0, '0, '0), 0, none);
        add_row(mk(OP_UNUSED, 5'd0, '0, 0, 0, '0, '0, '0), 1, none);

        // hold reset, then release it at a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

        // random traffic: sender mostly busy, then receiver mostly busy, then no gaps
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 6 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_request(random_request(), 0, none);
        end
        @(negedge clk);
        req_valid <= 1'b0;

        // drain outstanding responses
        while (responses_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d write, %0d read and %0d probe beats (%0d hits), %0d unused-op beats",
                 n_writes, n_reads, n_probes, n_hits, n_unused);
        $display("Back-pressure on both channels, %0d mismatches", error_count);
        if (error_count == 0)
            $display("tb_tlb_tag_match_array: PASS");
        else
            $display("tb_tlb_tag_match_array: FAIL");
        $finish;
    end

endmodule
